FILE: src/lanr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lanr_pkg
// Shared constants, types and the per-level step table of the noise reducer.
// ----------------------------------------------------------------------------
package lanr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 48;
   localparam int STEP_W   = 18;

   localparam logic [0:0] REG_ENABLE = 1'b0;
   localparam logic [0:0] REG_LEVEL  = 1'b1;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // step factor mu/(1+mu*taps), Q0.24, indexed by level
   function automatic logic [STEP_W-1:0] step_of(input logic [3:0] lvl);
      logic [STEP_W-1:0] s;
      case (lvl)
         4'd1:    s = 18'd101680;
         4'd2:    s = 18'd120778;
         4'd3:    s = 18'd131660;
         4'd4:    s = 18'd136596;
         4'd5:    s = 18'd137518;
         4'd6:    s = 18'd135872;
         4'd7:    s = 18'd132667;
         4'd8:    s = 18'd128578;
         4'd9:    s = 18'd124046;
         default: s = 18'd119350;
      endcase
      return s;
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
      return s[ACC_W-1:0];
   endfunction

   // sequencer control handed to the datapath
   typedef struct packed {
      logic clr;      // clear accumulator
      logic mac;      // accumulate product of weight and tap
      logic upd;      // write back updated weight
   } dp_ctl_type;

endpackage

FILE: src/lms_adaptive_noise_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_adaptive_noise_reducer
// LMS adaptive line enhancer: circular delay line, adaptive FIR, NLMS update.
// ----------------------------------------------------------------------------
// The lanr_mac unit serves both passes over the taps (estimate, then weight
// update). The weight store has a single RAM port, so each weight is read and
// then written back in the update pass; the number of taps runs from 40 to 112.
// With enable low the sample passes through S_RSP to the result register. A new
// sample is taken in the cycle after the previous result is accepted. Writing
// level clears the delay line and weights in a sweep over all MAX_TAPS entries,
// during which no sample is taken.
module lms_adaptive_noise_reducer #(
   parameter int MAX_TAPS   = 112,
   parameter int COEF_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sample_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_sample_out,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   localparam int AW = $clog2(MAX_TAPS);
   localparam int TW = $clog2(MAX_TAPS + 1);
   localparam int ACCW = lanr_pkg::ACC_W;

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_WRX = 4'd2,
      S_MAC = 4'd3, S_MACL = 4'd4, S_DES = 4'd5, S_DESW = 4'd6, S_ERR = 4'd7,
      S_GAIN = 4'd8, S_UPD = 4'd9, S_UPDW = 4'd10, S_OUT = 4'd11, S_OUTM = 4'd12,
      S_RSP = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic        enable_ff;
   logic [3:0]  level_ff;
   logic [TW-1:0] taps_ff;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] cnt_ff, cnt_in;     // tap index j
   logic [AW-1:0] hidx_ff, hidx_in;   // history address (p - j) mod taps
   logic        upd_phase_ff;
   logic [15:0] x_ff;
   logic [15:0] out_ff;
   logic        rsp_valid_ff;
   logic [ACCW-1:0] err_ff;
   logic [31:0] gain_ff;
   logic [ACCW+17:0] gprod_ff;

   // RAM ports
   logic           h_we, c_we;
   logic [AW-1:0]  h_addr, c_addr;
   logic [15:0]    h_wdata, h_rdata;
   logic [COEF_WIDTH-1:0] c_wdata, c_rdata, coef_new;
   logic [ACCW-1:0] acc;
   lanr_pkg::dp_ctl_type ctl;

   lanr_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_hist (
      .clock(clock), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
   lanr_ram #(.WIDTH(COEF_WIDTH), .DEPTH(MAX_TAPS)) u_coef (
      .clock(clock), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata));

   lanr_mac #(.COEF_WIDTH(COEF_WIDTH)) u_mac (
      .clock(clock), .ctl(ctl), .coef(c_rdata), .tap(h_rdata), .gain(gain_ff),
      .acc(acc), .coef_new(coef_new));

   function automatic logic [TW-1:0] taps_of(input logic [3:0] v);
      logic [3:0] l;
      logic [8:0] t;
      l = (v == 4'd0) ? 4'd1 : ((v > 4'd10) ? 4'd10 : v);
      t = 9'd32 + {2'b0, l, 3'b0};
      return (t > 9'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(t);
   endfunction

   function automatic logic [AW-1:0] dec_mod(input logic [AW-1:0] a,
                                             input logic [TW-1:0] t);
      return (a == '0) ? AW'(t - 1'b1) : a - 1'b1;
   endfunction

   logic [AW-1:0] last;
   logic [TW-1:0] half;
   logic [AW:0]   dsum;
   assign last = AW'(taps_ff - 1'b1);
   assign half = taps_ff >> 1;
   // (p + taps - taps/2) mod taps
   assign dsum = {1'b0, wp_ff} + (AW+1)'(taps_ff - half);

   logic [ACCW-1:0] desired, err_full, err_clamp, mag;
   logic [31:0] eupd;
   logic [ACCW+17:0] gprod;
   logic [ACCW+15:0] mprod;
   logic [28:0] one_q28;

   assign one_q28 = 29'h1000_0000;
   assign desired = {{(ACCW-29){h_rdata[15]}}, h_rdata, 13'd0};

   always_comb begin
      err_full = lanr_pkg::sat_add(desired, ~acc + 1'b1);
      // negating the most negative accumulator overflows by one
      if (acc == lanr_pkg::ACC_MIN)
         err_full = desired[ACCW-1] ? lanr_pkg::sat_add(desired + 1'b1, lanr_pkg::ACC_MAX)
                                    : lanr_pkg::ACC_MAX;
   end

   always_comb begin
      if ($signed(err_ff) > $signed(48'sh7FFF_FFFF)) eupd = 32'h7FFF_FFFF;
      else if ($signed(err_ff) < -$signed(48'sh8000_0000)) eupd = 32'h8000_0000;
      else eupd = err_ff[31:0];
      if ($signed(err_ff) > $signed({19'd0, one_q28})) err_clamp = {19'd0, one_q28};
      else if ($signed(err_ff) < -$signed({19'd0, one_q28}))
         err_clamp = -{19'd0, one_q28};
      else err_clamp = err_ff;
      mag = err_clamp[ACCW-1] ? -err_clamp : err_clamp;
   end
   assign gprod = (ACCW+18)'($signed(eupd) * $signed({1'b0, lanr_pkg::step_of(level_ff)}));
   assign mprod = (ACCW+16)'(mag[28:0] * 15'd32767);

   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff;
      cnt_in = cnt_ff;
      hidx_in = hidx_ff;
      h_we = 1'b0; h_addr = hidx_ff; h_wdata = x_ff;
      c_we = 1'b0; c_addr = cnt_ff; c_wdata = coef_new;
      ctl = '0;
      unique case (state_ff)
         S_CLEAR: begin
            h_we = 1'b1; c_we = 1'b1; h_addr = cnt_ff; h_wdata = '0; c_wdata = '0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(MAX_TAPS - 1)) begin
               cnt_in = '0; state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               if (enable_ff) state_in = S_WRX;
               else state_in = S_RSP;
            end
         end
         S_WRX: begin
            h_we = 1'b1; h_addr = wp_ff;
            cnt_in = '0; hidx_in = wp_ff;
            ctl.clr = 1'b1;
            state_in = S_MAC;
         end
         S_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            hidx_in = dec_mod(hidx_ff, taps_ff);
            if (cnt_ff == last) state_in = S_MACL;
         end
         S_MACL: state_in = S_DES;
         S_DES: begin
            h_addr = (dsum >= (AW+1)'(taps_ff)) ? AW'(dsum - (AW+1)'(taps_ff)) : AW'(dsum);
            state_in = S_DESW;
         end
         S_DESW: state_in = S_ERR;
         S_ERR: state_in = S_GAIN;
         S_GAIN: begin
            cnt_in = '0; hidx_in = wp_ff;
            state_in = S_UPD;
         end
         S_UPD: begin
            // even cycle reads weight j, odd cycle writes it back
            if (upd_phase_ff) begin
               c_we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               hidx_in = dec_mod(hidx_ff, taps_ff);
               if (cnt_ff == last) state_in = S_UPDW;
            end
         end
         S_UPDW: begin
            wp_in = (wp_ff == last) ? '0 : wp_ff + 1'b1;
            state_in = S_OUT;
         end
         S_OUT: state_in = S_OUTM;
         S_OUTM: state_in = S_IDLE;
         S_RSP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // products for the previous address come back in the next cycle
      if (state_ff == S_MAC || state_ff == S_MACL) ctl.mac = (state_ff != S_WRX);
      if (state_ff == S_MAC && cnt_ff == '0) ctl.mac = 1'b0;
      ctl.upd = c_we && (state_ff == S_UPD);
      // a level write restarts the clear sweep
      if (csr_we && csr_index == lanr_pkg::REG_LEVEL) begin
         state_in = S_CLEAR;
         wp_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         enable_ff <= 1'b0;
         level_ff <= 4'd5;
         taps_ff <= taps_of(4'd5);
         wp_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff <= wp_in;
         cnt_ff <= cnt_in;
         if (state_ff == S_RSP || state_ff == S_OUTM) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_we && csr_index == lanr_pkg::REG_ENABLE) enable_ff <= csr_wdata[0];
         if (csr_we && csr_index == lanr_pkg::REG_LEVEL) begin
            level_ff <= (csr_wdata == 4'd0) ? 4'd1 : ((csr_wdata > 4'd10) ? 4'd10 : csr_wdata);
            taps_ff <= taps_of(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      hidx_ff <= hidx_in;
      if (state_ff == S_IDLE) x_ff <= req_sample_in;
      if (state_ff == S_DESW) err_ff <= err_full;
      if (state_ff == S_ERR) gprod_ff <= gprod;
      if (state_ff == S_GAIN) gain_ff <= 32'(gprod_ff >>> 24);
      if (state_ff == S_RSP) out_ff <= x_ff;
      if (state_ff == S_OUT) begin
         out_ff <= err_clamp[ACCW-1] ? 16'(-mprod[43:28]) : mprod[43:28];
      end
   end

   // update pipeline: each weight is read, then written back, to keep the single port free
   always_ff @(posedge clock) begin
      if (reset) upd_phase_ff <= 1'b0;
      else upd_phase_ff <= (state_ff == S_UPD) ? ~upd_phase_ff : 1'b0;
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

   // the accumulator clears only when a filtered sample starts, and the estimate pass follows
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRX) |=> (state_ff == S_MAC))
      else $error("estimate pass did not start");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("input taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RSP || $past(state_ff) == S_OUTM))
      else $error("result without a sample");
endmodule

FILE: src/lanr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lanr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lanr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 112
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

FILE: src/lanr_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lanr_mac
// Shared multiply unit: weight*tap accumulation for the estimate, and
// weight + gain*tap saturating update.
// ----------------------------------------------------------------------------
module lanr_mac #(
   parameter int COEF_WIDTH = 32
) (
   input  logic                      clock,
   input  lanr_pkg::dp_ctl_type      ctl,
   input  logic [COEF_WIDTH-1:0]     coef,
   input  logic [15:0]               tap,
   input  logic [31:0]               gain,
   output logic [lanr_pkg::ACC_W-1:0] acc,
   output logic [COEF_WIDTH-1:0]     coef_new
);
   localparam int PW  = COEF_WIDTH + 16;
   localparam int AW  = lanr_pkg::ACC_W;
   localparam int TMW = PW - 15;
   localparam int SW  = (TMW > AW ? TMW : AW) + 1;
   localparam int UW  = (COEF_WIDTH > 33 ? COEF_WIDTH : 33) + 1;

   logic signed [PW-1:0]  prod;
   logic signed [TMW-1:0] term;
   logic signed [SW-1:0]  asum;
   logic [AW-1:0] acc_ff, acc_in;
   logic signed [47:0] gprod;
   logic signed [32:0] delta;
   logic signed [UW-1:0] wsum;
   logic signed [COEF_WIDTH-1:0] wmax, wmin;

   assign prod = $signed(coef) * $signed(tap);
   assign term = prod[PW-1:15];
   assign asum = SW'($signed(acc_ff)) + SW'(term);
   assign gprod = $signed(gain) * $signed(tap);
   assign delta = gprod[47:15];
   assign wsum = UW'($signed(coef)) + UW'(delta);
   assign wmax = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   assign wmin = {1'b1, {(COEF_WIDTH-1){1'b0}}};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clr) acc_in = '0;
      else if (ctl.mac) begin
         if (asum > SW'($signed(lanr_pkg::ACC_MAX))) acc_in = lanr_pkg::ACC_MAX;
         else if (asum < SW'($signed(lanr_pkg::ACC_MIN))) acc_in = lanr_pkg::ACC_MIN;
         else acc_in = asum[AW-1:0];
      end
      if (wsum > UW'(wmax)) coef_new = wmax;
      else if (wsum < UW'(wmin)) coef_new = wmin;
      else coef_new = wsum[COEF_WIDTH-1:0];
   end

   always_ff @(posedge clock) acc_ff <= acc_in;
   assign acc = acc_ff;
endmodule

FILE: sim/lanr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lanr_checker
// Watches the request, response and register ports of the noise reducer,
// keeps its own copy of the delay line and weights, predicts every cleaned
// sample and compares it with the response stream in order.
// ----------------------------------------------------------------------------
module lanr_checker #(
   parameter int MAX_TAPS   = 112,
   parameter int COEF_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_sample_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_sample_out,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   output int          error_count,
   output int          pending
);

   localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam longint W_HI   = (64'sd1 <<< (COEF_WIDTH - 1)) - 1;
   localparam longint W_LO   = -W_HI - 1;
   localparam longint E32_HI = (64'sd1 <<< 31) - 1;
   localparam longint E32_LO = -(64'sd1 <<< 31);
   localparam longint UNITY  = 64'sd1 <<< 28;

   logic           filter_on;
   int             gain_level;
   int             tap_count;
   int             head;
   longint         delay_line [MAX_TAPS];
   longint         weights [MAX_TAPS];
   logic [15:0]    cleaned_q [$];

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // normalized step, Q0.24, per level
   function automatic longint step_for(input int lvl);
      case (lvl)
         1: return 101680;
         2: return 120778;
         3: return 131660;
         4: return 136596;
         5: return 137518;
         6: return 135872;
         7: return 132667;
         8: return 128578;
         9: return 124046;
         default: return 119350;
      endcase
   endfunction

   function automatic void set_gain_level(input int v);
      int t;
      gain_level = v < 1 ? 1 : (v > 10 ? 10 : v);
      t = 32 + 8 * gain_level;
      tap_count = t > MAX_TAPS ? MAX_TAPS : t;
      for (int i = 0; i < MAX_TAPS; i++) begin
         delay_line[i] = 0;
         weights[i] = 0;
      end
      head = 0;
   endfunction

   function automatic logic [15:0] clean_sample(input logic [15:0] raw);
      longint x, acc, err, gain, mag, y;
      int p, k;
      if (!filter_on) return raw;
      x = longint'($signed(raw));
      p = head % tap_count;
      delay_line[p] = x;
      acc = 0;
      for (int j = 0; j < tap_count; j++) begin
         k = (p + tap_count - j) % tap_count;
         acc = clamp(acc + ((weights[j] * delay_line[k]) >>> 15), ACC_LO, ACC_HI);
      end
      k = (p + tap_count - tap_count / 2) % tap_count;
      err = clamp(delay_line[k] * 8192 - acc, ACC_LO, ACC_HI);
      gain = (clamp(err, E32_LO, E32_HI) * step_for(gain_level)) >>> 24;
      for (int j = 0; j < tap_count; j++) begin
         k = (p + tap_count - j) % tap_count;
         weights[j] = clamp(weights[j] + ((gain * delay_line[k]) >>> 15), W_LO, W_HI);
      end
      head = (p + 1) % tap_count;
      err = clamp(err, -UNITY, UNITY);
      mag = err < 0 ? -err : err;
      mag = (mag * 32767) >>> 28;
      y = err < 0 ? -mag : mag;
      return y[15:0];
   endfunction

   initial begin
      error_count = 0;
      pending = 0;
      filter_on = 1'b0;
      set_gain_level(5);
   end

   always @(posedge clock) begin
      if (reset) begin
         filter_on <= 1'b0;
         set_gain_level(5);
         cleaned_q.delete();
      end else begin
         // compare first so a response never matches a same-edge request
         if (rsp_valid && !rsp_stall) begin
            if (cleaned_q.size() == 0) begin
               $display("%0t: unexpected response, expected none got %0d",
                        $time, $signed(rsp_sample_out));
               error_count++;
            end else begin
               if (rsp_sample_out !== cleaned_q[0]) begin
                  $display("%0t: sample_out mismatch, expected %0d got %0d",
                           $time, $signed(cleaned_q[0]), $signed(rsp_sample_out));
                  error_count++;
               end
               void'(cleaned_q.pop_front());
            end
         end
         if (csr_we) begin
            if (csr_index == lanr_pkg::REG_ENABLE) filter_on <= csr_wdata[0];
            else if (csr_index == lanr_pkg::REG_LEVEL) set_gain_level(int'(csr_wdata));
         end
         if (req_valid && !req_stall) cleaned_q.push_back(clean_sample(req_sample_in));
      end
      pending <= cleaned_q.size();
   end

endmodule

FILE: sim/lms_adaptive_noise_reducer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_adaptive_noise_reducer_tb
// Drives directed and random audio through the noise reducer across enable
// and level settings, with random gaps and back-pressure; the checker
// predicts and compares every cleaned sample.
// ----------------------------------------------------------------------------
module lms_adaptive_noise_reducer_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_sample_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_sample_out;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [3:0]  csr_wdata;
   int          error_count;
   int          pending;

   logic        want_hold;
   logic        hold_done;
   logic        no_stall;
   logic        tight;

   lms_adaptive_noise_reducer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   lanr_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

   // response side back-pressure
   initial begin
      int run_left, hold_left;
      logic stall_val;
      run_left = 0;
      hold_left = 0;
      stall_val = 1'b0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (want_hold && !hold_done) begin
            hold_left = 3000;
            hold_done <= 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (no_stall) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               stall_val = $urandom_range(0, 99) < 60 ? 1'b0 : 1'b1;
               run_left = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 3);
            end
            run_left--;
            rsp_stall <= stall_val;
         end
      end
   end

   task automatic send(input logic [15:0] s);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      gap = (tight || r < 70) ? 0 : (r < 95 ? $urandom_range(1, 4) : $urandom_range(10, 50));
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      // allow for work still in flight and the clear sweep
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] audio_sample(input int n, input int period, input int amp);
      int ph, v, r;
      r = $urandom_range(0, 99);
      if (r < 20) return 16'($urandom);
      if (r < 30) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      ph = n % period;
      if (ph < period / 2) v = -amp + (4 * amp * ph) / period;
      else v = 3 * amp - (4 * amp * ph) / period;
      v += $signed($urandom_range(0, 2047)) - 1024;
      v = v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
      return 16'(v);
   endfunction

   initial begin
      logic [15:0] edge_vals [8];
      int period, amp;
      req_valid = 1'b0;
      req_sample_in = '0;
      csr_we = 1'b0;
      csr_index = lanr_pkg::REG_ENABLE;
      csr_wdata = '0;
      want_hold = 1'b0;
      no_stall = 1'b0;
      tight = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                    16'h0001, 16'h5555, 16'hAAAA, 16'h7FFE};
      // pass-through while disabled
      foreach (edge_vals[i]) send(edge_vals[i]);
      drain();
      write_reg(lanr_pkg::REG_ENABLE, 4'd1);
      for (int i = 0; i < 6; i++) send(i % 2 ? 16'h8000 : 16'h7FFF);
      drain();
      // out-of-range levels clamp to 1 and 10
      write_reg(lanr_pkg::REG_LEVEL, 4'd0);
      for (int i = 0; i < 3; i++) send(16'h7FFF);
      drain();
      write_reg(lanr_pkg::REG_LEVEL, 4'd15);
      for (int i = 0; i < 3; i++) send(16'h8000);
      drain();
      // toggling enable keeps the filter state
      write_reg(lanr_pkg::REG_ENABLE, 4'd0);
      send(16'h1234);
      drain();
      write_reg(lanr_pkg::REG_ENABLE, 4'd1);
      for (int i = 0; i < 3; i++) send(16'h7FFF);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(lanr_pkg::REG_LEVEL,
                   ph == 0 ? 4'd1 : (ph == 1 ? 4'd10 : 4'($urandom_range(0, 15))));
         write_reg(lanr_pkg::REG_ENABLE, ph == 5 ? 4'd0 : 4'd1);
         no_stall <= (ph == 2);
         tight <= (ph == 3);
         if (ph == 4) want_hold <= 1'b1;
         period = $urandom_range(4, 40);
         amp = $urandom_range(500, 30000);
         for (int n = 0; n < 200; n++) send(audio_sample(n, period, amp));
         drain();
      end

      if (error_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
src/lanr_pkg.sv
src/lanr_ram.sv
src/lanr_mac.sv
src/lms_adaptive_noise_reducer.sv
sim/lanr_checker.sv
sim/lms_adaptive_noise_reducer_tb.sv
